### sv/tsfu_pkg.sv
// ----------------------------------------------------------------------------
// Task signal flag unit package
// Shared constants, request and status codes, and the words of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package tsfu_pkg;

   localparam int NUM_TASKS    = 16;
   localparam int SIGNAL_COUNT = 27;

   localparam int TASK_W     = 4;
   localparam int FIELD_W    = 27;
   localparam int TASK_IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int USED_BITS  = (SIGNAL_COUNT < FIELD_W) ? SIGNAL_COUNT : FIELD_W;

   localparam logic [FIELD_W-1:0] SIG_MASK = FIELD_W'((64'd1 << USED_BITS) - 64'd1);

   localparam logic [2:0] REQ_ALLOC    = 3'd0;
   localparam logic [2:0] REQ_FREE     = 3'd1;
   localparam logic [2:0] REQ_SEND     = 3'd2;
   localparam logic [2:0] REQ_SEND_IRQ = 3'd3;
   localparam logic [2:0] REQ_WAIT     = 3'd4;

   localparam logic [1:0] ST_OK            = 2'd0;
   localparam logic [1:0] ST_NO_SIGNAL     = 2'd1;
   localparam logic [1:0] ST_NOT_ALLOCATED = 2'd2;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [TASK_W-1:0]  task_id;
      logic [FIELD_W-1:0] signal_bits;
   } req_word_type;

   typedef struct packed {
      logic [FIELD_W-1:0] result_bits;
      logic [1:0]         status;
      logic               task_woken;
      logic               task_blocked;
      logic               switch_request;
   } rsp_word_type;

endpackage

`default_nettype wire

### sv/tsfu_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one request word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsfu_req_if;
   logic                  valid;
   logic                  ready;
   tsfu_pkg::req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/tsfu_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one response word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsfu_rsp_if;
   logic                  valid;
   logic                  ready;
   tsfu_pkg::rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/task_signal_flag_unit.sv
// ----------------------------------------------------------------------------
// Task signal flag unit
// Keeps allocated, received and wait masks and a waiting flag for each task.
// ----------------------------------------------------------------------------
// A request word enters on req_if: alloc, free, send, send from interrupt or
// wait, for one task. Every request gives exactly one response word on
// rsp_if, in order.
// A request is held in an input register; from there the state of its task is
// read and updated, and the response is written to the output register.
// One request is taken in every cycle while the response side keeps up; the
// throughput is set by the single read-modify-write of the task's masks.
// When the receiver stalls, the response is held and the request behind it
// stays in the input register; req_if.ready falls only when both are full.
// Synchronous reset clears every mask and waiting flag and empties both
// registers; no request is lost across a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module task_signal_flag_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   tsfu_req_if.sink   req_if,
   tsfu_rsp_if.source rsp_if
);

   localparam int NT = tsfu_pkg::NUM_TASKS;
   localparam int FW = tsfu_pkg::FIELD_W;
   localparam int IW = tsfu_pkg::TASK_IDX_W;

   logic [FW-1:0] alloc_ff [NT];
   logic [FW-1:0] recv_ff  [NT];
   logic [FW-1:0] wait_ff  [NT];
   logic [NT-1:0] waiting_ff;

   logic                   req_valid_ff;
   tsfu_pkg::req_word_type req_word_ff;
   logic                   rsp_valid_ff;
   tsfu_pkg::rsp_word_type rsp_word_ff;

   logic                   advance;
   logic                   in_range;
   logic [IW-1:0]          idx;
   logic [FW-1:0]          sig;
   logic [FW-1:0]          cur_alloc, cur_recv, cur_wait;
   logic                   cur_waiting;
   logic [FW-1:0]          free_bits, one_bit, match;
   logic [FW-1:0]          alloc_in, recv_in, wait_in;
   logic                   waiting_in;
   tsfu_pkg::rsp_word_type rsp_word_in;

   assign advance       = req_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !req_valid_ff || advance;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.data   = rsp_word_ff;

   assign in_range    = (32'(req_word_ff.task_id) < NT);
   assign idx         = IW'(req_word_ff.task_id);
   assign sig         = req_word_ff.signal_bits & tsfu_pkg::SIG_MASK;
   assign cur_alloc   = alloc_ff[idx];
   assign cur_recv    = recv_ff[idx];
   assign cur_wait    = wait_ff[idx];
   assign cur_waiting = waiting_ff[idx];
   assign free_bits   = ~cur_alloc & tsfu_pkg::SIG_MASK;
   assign one_bit     = free_bits & (~free_bits + FW'(1));
   assign match       = sig & cur_recv;

   always_comb begin
      alloc_in    = cur_alloc;
      recv_in     = cur_recv;
      wait_in     = cur_wait;
      waiting_in  = cur_waiting;
      rsp_word_in = '0;
      if (in_range) begin
         case (req_word_ff.req_type)
            tsfu_pkg::REQ_ALLOC: begin
               if (free_bits == '0) begin
                  rsp_word_in.status = tsfu_pkg::ST_NO_SIGNAL;
               end else begin
                  alloc_in                = cur_alloc | one_bit;
                  recv_in                 = cur_recv & ~one_bit;
                  wait_in                 = cur_wait & ~one_bit;
                  rsp_word_in.result_bits = one_bit;
               end
            end
            tsfu_pkg::REQ_FREE: begin
               if ((cur_alloc & sig) == '0) begin
                  rsp_word_in.status = tsfu_pkg::ST_NOT_ALLOCATED;
               end
               alloc_in = cur_alloc & ~sig;
            end
            tsfu_pkg::REQ_SEND, tsfu_pkg::REQ_SEND_IRQ: begin
               recv_in = cur_recv | sig;
               if (cur_waiting && ((cur_wait & sig) != '0)) begin
                  waiting_in                 = 1'b0;
                  rsp_word_in.task_woken     = 1'b1;
                  rsp_word_in.switch_request =
                     (req_word_ff.req_type == tsfu_pkg::REQ_SEND);
               end
            end
            tsfu_pkg::REQ_WAIT: begin
               wait_in = sig;
               if (match == '0) begin
                  waiting_in                 = 1'b1;
                  rsp_word_in.task_blocked   = 1'b1;
                  rsp_word_in.switch_request = 1'b1;
               end else begin
                  recv_in                 = cur_recv & ~match;
                  waiting_in              = 1'b0;
                  rsp_word_in.result_bits = match;
               end
            end
            default: begin
               rsp_word_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         waiting_ff   <= '0;
         for (int i = 0; i < NT; i++) begin
            alloc_ff[i] <= '0;
            recv_ff[i]  <= '0;
            wait_ff[i]  <= '0;
         end
      end else begin
         if (req_if.ready) begin
            req_valid_ff <= req_if.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance && in_range) begin
            alloc_ff[idx]   <= alloc_in;
            recv_ff[idx]    <= recv_in;
            wait_ff[idx]    <= wait_in;
            waiting_ff[idx] <= waiting_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         req_word_ff <= req_if.data;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

`default_nettype wire

### sv/tsfu_checker.sv
// ----------------------------------------------------------------------------
// Task signal flag unit checker
// Port-level assertions on the response words, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tsfu_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire tsfu_pkg::rsp_word_type rsp_data
);

   // A stalled response word must stay put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid directly after reset");

   a_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.task_blocked |->
         rsp_data.switch_request && rsp_data.result_bits == '0 &&
         !rsp_data.task_woken && rsp_data.status == tsfu_pkg::ST_OK)
      else $error("blocked wait with inconsistent fields");

   a_woken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.task_woken |->
         rsp_data.result_bits == '0 && rsp_data.status == tsfu_pkg::ST_OK)
      else $error("wake with inconsistent fields");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != tsfu_pkg::ST_OK |->
         rsp_data.result_bits == '0 && !rsp_data.switch_request &&
         (rsp_data.status == tsfu_pkg::ST_NO_SIGNAL ||
          rsp_data.status == tsfu_pkg::ST_NOT_ALLOCATED))
      else $error("error status with inconsistent fields");

endmodule

bind task_signal_flag_unit tsfu_checker u_tsfu_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_data  (rsp_if.data)
);

`default_nettype wire

### tb/task_signal_flag_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task signal flag unit testbench
// Drives alloc, free, send, interrupt send and wait request words in bursts,
// stalls the response side on a changing pattern, and checks each response
// word against a cycle-free model of the per-task signal masks.
// ----------------------------------------------------------------------------

module task_signal_flag_unit_test;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tsfu_req_if req_ch ();
   tsfu_rsp_if rsp_ch ();

   task_signal_flag_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   logic [tsfu_pkg::FIELD_W-1:0] flags_allocated [tsfu_pkg::NUM_TASKS];
   logic [tsfu_pkg::FIELD_W-1:0] flags_received  [tsfu_pkg::NUM_TASKS];
   logic [tsfu_pkg::FIELD_W-1:0] flags_armed     [tsfu_pkg::NUM_TASKS];
   logic                         task_is_waiting [tsfu_pkg::NUM_TASKS];

   tsfu_pkg::req_word_type pending_reqs [$];
   tsfu_pkg::rsp_word_type expected_rsps [$];

   int mismatch_count = 0;
   int live_items     = 0;
   int burst_left     = 1;
   int gap_left       = 0;
   int stall_mode     = 0;
   int cycle_count    = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic tsfu_pkg::rsp_word_type predict_flags(
      input tsfu_pkg::req_word_type w);
      tsfu_pkg::rsp_word_type       r;
      logic [tsfu_pkg::FIELD_W-1:0] sig;
      logic [tsfu_pkg::FIELD_W-1:0] avail;
      logic [tsfu_pkg::FIELD_W-1:0] pick;
      logic [tsfu_pkg::FIELD_W-1:0] hit;
      int                           k;
      r   = '0;
      sig = w.signal_bits & tsfu_pkg::SIG_MASK;
      k   = int'(w.task_id);
      if (k < tsfu_pkg::NUM_TASKS) begin
         case (w.req_type)
            tsfu_pkg::REQ_ALLOC: begin
               avail = ~flags_allocated[k] & tsfu_pkg::SIG_MASK;
               if (avail == '0) begin
                  r.status = tsfu_pkg::ST_NO_SIGNAL;
               end else begin
                  pick = avail & (~avail + 1'b1);
                  flags_allocated[k] |= pick;
                  flags_received[k]  &= ~pick;
                  flags_armed[k]     &= ~pick;
                  r.result_bits = pick;
               end
            end
            tsfu_pkg::REQ_FREE: begin
               if ((flags_allocated[k] & sig) == '0) begin
                  r.status = tsfu_pkg::ST_NOT_ALLOCATED;
               end
               flags_allocated[k] &= ~sig;
            end
            tsfu_pkg::REQ_SEND, tsfu_pkg::REQ_SEND_IRQ: begin
               flags_received[k] |= sig;
               if (task_is_waiting[k] && (flags_armed[k] & sig) != '0) begin
                  task_is_waiting[k] = 1'b0;
                  r.task_woken     = 1'b1;
                  r.switch_request = (w.req_type == tsfu_pkg::REQ_SEND);
               end
            end
            tsfu_pkg::REQ_WAIT: begin
               flags_armed[k] = sig;
               hit = sig & flags_received[k];
               if (hit == '0) begin
                  task_is_waiting[k] = 1'b1;
                  r.task_blocked   = 1'b1;
                  r.switch_request = 1'b1;
               end else begin
                  flags_received[k] &= ~hit;
                  task_is_waiting[k] = 1'b0;
                  r.result_bits = hit;
               end
            end
            default: begin
            end
         endcase
      end
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch on %s: got %h, want %h", $realtime, field, got, want);
      mismatch_count++;
   endtask

   task automatic queue_req(input logic [2:0] kind, input int unsigned tsk,
                            input logic [tsfu_pkg::FIELD_W-1:0] bits);
      tsfu_pkg::req_word_type w;
      w.req_type    = kind;
      w.task_id     = tsfu_pkg::TASK_W'(tsk);
      w.signal_bits = bits;
      pending_reqs.push_back(w);
      if (kind <= tsfu_pkg::REQ_WAIT) begin
         live_items++;
      end
   endtask

   // Request driver: bursts of words separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_rsps.push_back(predict_flags(req_ch.data));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_ch.data  <= pending_reqs.pop_front();
               req_ch.valid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response side: a randomly chosen stall pattern drives ready.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count % 256 == 0) begin
         stall_mode = $urandom_range(0, 3);
      end
      case (stall_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= ($urandom_range(0, 2) != 0);
         2: rsp_ch.ready <= ((cycle_count % 5) < 2);
         default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Response monitor.
   always @(posedge clock) begin
      tsfu_pkg::rsp_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected word", 32'(rsp_ch.data), 32'd0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_ch.data.result_bits !== want.result_bits)
               report_mismatch("result_bits", 32'(rsp_ch.data.result_bits),
                               32'(want.result_bits));
            if (rsp_ch.data.status !== want.status)
               report_mismatch("status", 32'(rsp_ch.data.status), 32'(want.status));
            if (rsp_ch.data.task_woken !== want.task_woken)
               report_mismatch("task_woken", 32'(rsp_ch.data.task_woken),
                               32'(want.task_woken));
            if (rsp_ch.data.task_blocked !== want.task_blocked)
               report_mismatch("task_blocked", 32'(rsp_ch.data.task_blocked),
                               32'(want.task_blocked));
            if (rsp_ch.data.switch_request !== want.switch_request)
               report_mismatch("switch_request", 32'(rsp_ch.data.switch_request),
                               32'(want.switch_request));
         end
      end
   end

   initial begin
      int unsigned                  tsk;
      int unsigned                  n;
      logic [tsfu_pkg::FIELD_W-1:0] bit_pick;
      logic [tsfu_pkg::FIELD_W-1:0] mask;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
      for (int i = 0; i < tsfu_pkg::NUM_TASKS; i++) begin
         flags_allocated[i] = '0;
         flags_received[i]  = '0;
         flags_armed[i]     = '0;
         task_is_waiting[i] = 1'b0;
      end

      queue_req(tsfu_pkg::REQ_ALLOC, 0, '0);
      queue_req(tsfu_pkg::REQ_ALLOC, 15, tsfu_pkg::SIG_MASK);
      queue_req(tsfu_pkg::REQ_FREE, 0, '0);
      queue_req(tsfu_pkg::REQ_FREE, 15, tsfu_pkg::FIELD_W'(32));
      queue_req(tsfu_pkg::REQ_ALLOC, 0, '0);
      queue_req(tsfu_pkg::REQ_FREE, 0, tsfu_pkg::FIELD_W'(1));
      queue_req(tsfu_pkg::REQ_ALLOC, 0, '0);
      queue_req(tsfu_pkg::REQ_SEND, 3, tsfu_pkg::SIG_MASK);
      queue_req(tsfu_pkg::REQ_WAIT, 3,
                tsfu_pkg::FIELD_W'(1) << (tsfu_pkg::FIELD_W - 1));
      queue_req(tsfu_pkg::REQ_WAIT, 3, '0);
      queue_req(tsfu_pkg::REQ_SEND, 3, tsfu_pkg::FIELD_W'(2));
      queue_req(tsfu_pkg::REQ_WAIT, 4, tsfu_pkg::FIELD_W'(16));
      queue_req(tsfu_pkg::REQ_SEND, 4, tsfu_pkg::FIELD_W'(16));
      queue_req(tsfu_pkg::REQ_WAIT, 4, tsfu_pkg::FIELD_W'(16));
      queue_req(tsfu_pkg::REQ_WAIT, 4, tsfu_pkg::FIELD_W'(3));
      queue_req(tsfu_pkg::REQ_SEND_IRQ, 4, tsfu_pkg::FIELD_W'(2));
      queue_req(tsfu_pkg::REQ_WAIT, 4, tsfu_pkg::FIELD_W'(3));
      queue_req(tsfu_pkg::REQ_SEND, 4, tsfu_pkg::FIELD_W'(4));
      queue_req(3'd5, 7, tsfu_pkg::SIG_MASK);
      queue_req(3'd6, 7, tsfu_pkg::FIELD_W'($urandom()));
      queue_req(3'd7, 7, tsfu_pkg::SIG_MASK);
      queue_req(tsfu_pkg::REQ_FREE, 0, tsfu_pkg::SIG_MASK);
      queue_req(tsfu_pkg::REQ_FREE, 0, tsfu_pkg::SIG_MASK);
      queue_req(tsfu_pkg::REQ_SEND, 0, tsfu_pkg::FIELD_W'(1));
      queue_req(tsfu_pkg::REQ_ALLOC, 0, '0);
      queue_req(tsfu_pkg::REQ_WAIT, 0, tsfu_pkg::FIELD_W'(1));

      while (live_items < 2000) begin
         tsk = $urandom_range(0, tsfu_pkg::NUM_TASKS - 1);
         case ($urandom_range(0, 9))
            0, 1: begin
               n = $urandom_range(20, 32);
               repeat (n) begin
                  if ($urandom_range(0, 9) == 0)
                     queue_req(tsfu_pkg::REQ_FREE, tsk, tsfu_pkg::FIELD_W'(1) <<
                               $urandom_range(0, tsfu_pkg::FIELD_W - 1));
                  else
                     queue_req(tsfu_pkg::REQ_ALLOC, tsk,
                               tsfu_pkg::FIELD_W'($urandom()));
               end
            end
            2, 3, 4, 5: begin
               bit_pick = tsfu_pkg::FIELD_W'(1) <<
                          $urandom_range(0, tsfu_pkg::FIELD_W - 1);
               mask     = bit_pick | (tsfu_pkg::FIELD_W'($urandom()) &
                                      tsfu_pkg::FIELD_W'($urandom()));
               queue_req(tsfu_pkg::REQ_ALLOC, tsk, '0);
               queue_req(tsfu_pkg::REQ_WAIT, tsk, mask);
               repeat ($urandom_range(0, 2)) begin
                  queue_req($urandom_range(0, 1) ? tsfu_pkg::REQ_SEND
                                                 : tsfu_pkg::REQ_SEND_IRQ, tsk,
                            tsfu_pkg::FIELD_W'($urandom()) & ~mask);
               end
               queue_req($urandom_range(0, 1) ? tsfu_pkg::REQ_SEND
                                              : tsfu_pkg::REQ_SEND_IRQ, tsk,
                         $urandom_range(0, 3) == 0 ? ~mask : bit_pick);
               queue_req(tsfu_pkg::REQ_WAIT, tsk,
                         $urandom_range(0, 4) == 0 ? '0 : mask);
               if ($urandom_range(0, 1))
                  queue_req(tsfu_pkg::REQ_FREE, tsk,
                            $urandom_range(0, 3) == 0 ? mask : bit_pick);
            end
            6, 7: begin
               repeat ($urandom_range(1, 8)) begin
                  queue_req(3'($urandom_range(0, 7)),
                            $urandom_range(0, tsfu_pkg::NUM_TASKS - 1),
                            tsfu_pkg::FIELD_W'($urandom()));
               end
            end
            default: begin
               repeat ($urandom_range(1, 4)) begin
                  queue_req(3'($urandom_range(tsfu_pkg::REQ_FREE, tsfu_pkg::REQ_WAIT)),
                            tsk,
                            tsfu_pkg::FIELD_W'($urandom()) &
                            tsfu_pkg::FIELD_W'($urandom()));
               end
            end
         endcase
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_ch.valid) @(negedge clock);
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
